@@ rtl/spe_pkg.sv @@
// ----------------------------------------------------------------------------
// spe_pkg
// shared types, constants and codes for the sram puf enrollment core
// ----------------------------------------------------------------------------
package spe_pkg;

    // window of sampled sram bytes, one counter row per byte
    localparam int WINDOW_BYTES = 32;
    localparam int ADDR_W       = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;

    localparam int LANES = 8;
    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // permille scale and width of the cross-multiplied compare
    localparam int SCALE = 1000;
    localparam int THR_W = $clog2(SCALE * (2 ** CNT_W));

    localparam int TOTAL_W = 16;
    localparam int TOL_W   = 9;
    localparam logic [TOTAL_W-1:0] TOTAL_RST = TOTAL_W'(1000);
    localparam logic [TOL_W-1:0]   TOL_RST   = TOL_W'(1);

    // apb register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_SAMPLE_TOTAL = 1'b0;
    localparam logic REG_TOLERANCE    = 1'b1;

    // action codes
    localparam logic [1:0] ACT_ACCUM  = 2'd0;
    localparam logic [1:0] ACT_STORE  = 2'd1;
    localparam logic [1:0] ACT_ENROLL = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [4:0] byte_index;
        logic [7:0] sample_byte;
    } spe_in_t;

    typedef struct packed {
        logic [4:0] out_index;
        logic [7:0] key_byte;
        logic [7:0] mask_byte;
        logic [7:0] helper_byte;
    } spe_out_t;

    // per-lane control of the read-modify-write stage
    typedef struct packed {
        logic              accum;
        logic              row_valid;
        logic [ADDR_W-1:0] addr;
    } spe_lane_ctrl_t;

endpackage

@@ rtl/spe_ram.sv @@
// ----------------------------------------------------------------------------
// spe_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module spe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                           clk,
    input  logic                                           we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  logic [WIDTH-1:0]                               wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                               rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/spe_lane.sv @@
// ----------------------------------------------------------------------------
// spe_lane
// one bit lane: counter ram, saturating increment and stability compare
// ----------------------------------------------------------------------------
module spe_lane (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [spe_pkg::ADDR_W-1:0]   rd_addr,
    input  spe_pkg::spe_lane_ctrl_t      ctrl,
    input  logic                         sample_bit,
    input  logic [spe_pkg::THR_W-1:0]    thr_hi,
    input  logic [spe_pkg::THR_W-1:0]    thr_lo,
    output logic                         stable
);

    logic [spe_pkg::CNT_W-1:0]  rdata;
    logic [spe_pkg::CNT_W-1:0]  count;
    logic [spe_pkg::CNT_W-1:0]  count_inc;
    logic [spe_pkg::THR_W-1:0]  scaled;

    // last write, forwarded to a read issued in the same cycle as that write
    logic                        lw_valid_reg, lw_valid_next;
    logic [spe_pkg::ADDR_W-1:0]  lw_addr_reg;
    logic [spe_pkg::CNT_W-1:0]   lw_data_reg;

    spe_ram #(
        .WIDTH (spe_pkg::CNT_W),
        .DEPTH (spe_pkg::WINDOW_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ctrl.accum),
        .waddr (ctrl.addr),
        .wdata (count_inc),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    always_comb
    begin
        if (lw_valid_reg && (lw_addr_reg == ctrl.addr))
        begin
            count = lw_data_reg;
        end
        else if (ctrl.row_valid)
        begin
            count = rdata;
        end
        else
        begin
            count = '0;
        end

        if (sample_bit && (count != spe_pkg::CNT_MAX))
        begin
            count_inc = count + spe_pkg::CNT_W'(1);
        end
        else
        begin
            count_inc = count;
        end

        scaled = spe_pkg::THR_W'(count) * spe_pkg::THR_W'(spe_pkg::SCALE);
        stable = (scaled >= thr_hi) || (scaled <= thr_lo);
    end

    assign lw_valid_next = ctrl.accum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            lw_valid_reg <= lw_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lw_addr_reg <= ctrl.addr;
        lw_data_reg <= count_inc;
    end

endmodule

@@ rtl/spe_merge.sv @@
// ----------------------------------------------------------------------------
// spe_merge
// combines lane stability flags with the reference into the result word
// ----------------------------------------------------------------------------
module spe_merge (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       enroll,
    input  logic [4:0]                 index,
    input  logic [7:0]                 ref_byte,
    input  logic [spe_pkg::LANES-1:0]  stable,
    output spe_pkg::spe_out_t          result,
    output logic                       result_strobe
);

    spe_pkg::spe_out_t result_reg, result_next;
    logic              strobe_reg, strobe_next;
    logic [7:0]        key;

    always_comb
    begin
        key                     = ref_byte & stable;
        result_next.out_index   = index;
        result_next.mask_byte   = stable;
        result_next.key_byte    = key;
        result_next.helper_byte = key ^ {8{key[7]}};
        strobe_next             = enroll;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result        = result_reg;
    assign result_strobe = strobe_reg;

endmodule

@@ rtl/sram_puf_enrollment_core.sv @@
// ----------------------------------------------------------------------------
// sram_puf_enrollment_core
// sram power-up puf enrollment with repetition-code helper data
// ----------------------------------------------------------------------------
// path: an enroll word is registered into the second stage word, then into the
//   merge output register, which strobes its result
// throughput: one word per cycle, busy stays low; set by the read-modify-write
//   of each lane's counter ram (registered read + bypass)
// reset: counters read as zero through per-row valid flops cleared at once,
//   no clearing pass; config returns to sample_total 1000, tolerance 1
// the receiver cannot stall: each result is shown for exactly one cycle
// ----------------------------------------------------------------------------
module sram_puf_enrollment_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // command side
    input  logic                          start,
    output logic                          busy,
    input  spe_pkg::spe_in_t              item,
    // result side
    output spe_pkg::spe_out_t             result,
    output logic                          result_strobe,
    // apb config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spe_pkg::PADDR_W-1:0]   paddr,
    input  logic [spe_pkg::PDATA_W-1:0]   pwdata,
    output logic [spe_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    // ------------------------------------------------------------------
    // config registers, thresholds are cross-multiplied at write time
    // ------------------------------------------------------------------
    logic [spe_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic [spe_pkg::TOL_W-1:0]   tol_reg, tol_next;
    logic [spe_pkg::THR_W-1:0]   thr_hi_reg, thr_hi_next;
    logic [spe_pkg::THR_W-1:0]   thr_lo_reg, thr_lo_next;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        total_next = total_reg;
        tol_next   = tol_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                spe_pkg::REG_SAMPLE_TOTAL: total_next = pwdata[spe_pkg::TOTAL_W-1:0];
                spe_pkg::REG_TOLERANCE:    tol_next   = pwdata[spe_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
        // high threshold (1000 - tol) * total, low threshold tol * total
        thr_hi_next = (spe_pkg::THR_W'(spe_pkg::SCALE) - spe_pkg::THR_W'(tol_next))
                      * spe_pkg::THR_W'(total_next);
        thr_lo_next = spe_pkg::THR_W'(tol_next) * spe_pkg::THR_W'(total_next);
    end

    always_comb
    begin
        case (paddr[2])
            spe_pkg::REG_SAMPLE_TOTAL: prdata = spe_pkg::PDATA_W'(total_reg);
            spe_pkg::REG_TOLERANCE:    prdata = spe_pkg::PDATA_W'(tol_reg);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= spe_pkg::TOTAL_RST;
            tol_reg    <= spe_pkg::TOL_RST;
            thr_hi_reg <= spe_pkg::THR_W'((spe_pkg::SCALE - int'(spe_pkg::TOL_RST))
                                          * int'(spe_pkg::TOTAL_RST));
            thr_lo_reg <= spe_pkg::THR_W'(int'(spe_pkg::TOL_RST) * int'(spe_pkg::TOTAL_RST));
        end
        else
        begin
            total_reg  <= total_next;
            tol_reg    <= tol_next;
            thr_hi_reg <= thr_hi_next;
            thr_lo_reg <= thr_lo_next;
        end
    end

    // ------------------------------------------------------------------
    // accept stage: decode, reference store, counter ram read
    // ------------------------------------------------------------------
    logic                        accept;
    logic                        in_window;
    logic [spe_pkg::ADDR_W-1:0]  in_addr;
    logic                        ref_we;
    logic [7:0]                  ref_rdata;

    assign accept    = start && !busy;
    assign in_window = (32'(item.byte_index) < spe_pkg::WINDOW_BYTES);
    assign in_addr   = spe_pkg::ADDR_W'(item.byte_index);
    assign ref_we    = accept && in_window && (item.action == spe_pkg::ACT_STORE);

    // reference bytes, undefined until written so no reset; the registered
    // read lines up with the second stage word
    spe_ram #(
        .WIDTH (8),
        .DEPTH (spe_pkg::WINDOW_BYTES)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (in_addr),
        .wdata (item.sample_byte),
        .raddr (in_addr),
        .rdata (ref_rdata)
    );

    // second stage word
    logic                        s1_valid_reg, s1_valid_next;
    logic [1:0]                  s1_action_reg;
    logic [4:0]                  s1_index_reg;
    logic [spe_pkg::ADDR_W-1:0]  s1_addr_reg;
    logic [7:0]                  s1_sample_reg;

    // only accumulate and enroll need the second stage
    assign s1_valid_next = accept && in_window &&
                           ((item.action == spe_pkg::ACT_ACCUM) ||
                            (item.action == spe_pkg::ACT_ENROLL));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_action_reg <= item.action;
        s1_index_reg  <= item.byte_index;
        s1_addr_reg   <= in_addr;
        s1_sample_reg <= item.sample_byte;
    end

    // ------------------------------------------------------------------
    // row valid flags: a row never accumulated reads as all-zero counts
    // ------------------------------------------------------------------
    logic [spe_pkg::WINDOW_BYTES-1:0] row_valid_reg, row_valid_next;
    logic                             s1_accum;
    logic                             s1_enroll;

    assign s1_accum  = s1_valid_reg && (s1_action_reg == spe_pkg::ACT_ACCUM);
    assign s1_enroll = s1_valid_reg && (s1_action_reg == spe_pkg::ACT_ENROLL);

    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (s1_accum)
        begin
            row_valid_next[s1_addr_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // eight bit lanes, lane b owns bit b of each byte
    // ------------------------------------------------------------------
    spe_pkg::spe_lane_ctrl_t     lane_ctrl;
    logic [spe_pkg::LANES-1:0]   lane_stable;

    assign lane_ctrl.accum     = s1_accum;
    assign lane_ctrl.row_valid = row_valid_reg[s1_addr_reg];
    assign lane_ctrl.addr      = s1_addr_reg;

    for (genvar b = 0; b < spe_pkg::LANES; b++)
    begin : g_lane
        spe_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .rd_addr    (in_addr),
            .ctrl       (lane_ctrl),
            .sample_bit (s1_sample_reg[b]),
            .thr_hi     (thr_hi_reg),
            .thr_lo     (thr_lo_reg),
            .stable     (lane_stable[b])
        );
    end

    // ------------------------------------------------------------------
    // merge: mask, key and helper word into the output register
    // ------------------------------------------------------------------
    spe_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .enroll        (s1_enroll),
        .index         (s1_index_reg),
        .ref_byte      (ref_rdata),
        .stable        (lane_stable),
        .result        (result),
        .result_strobe (result_strobe)
    );

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_strobe_from_enroll: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(accept && in_window &&
                                (item.action == spe_pkg::ACT_ENROLL), 2))
        else $error("result strobe without an enroll word two cycles earlier");

    a_no_result_other: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.action != spe_pkg::ACT_ENROLL)) |=> ##1 !result_strobe)
        else $error("result strobe after a non-enroll word");

    a_index_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (result.out_index == $past(item.byte_index, 2)))
        else $error("result index does not match its enroll word");

    a_row_valid_set: assert property (@(posedge clk) disable iff (!rst_n)
        s1_accum |=> row_valid_reg[$past(s1_addr_reg)])
        else $error("accumulated row not marked valid");

endmodule

@@ tb/sram_puf_enrollment_core_tb.sv @@
// ----------------------------------------------------------------------------
// sram_puf_enrollment_core_tb
// self-checking bench for the puf enrollment core: words go in on the command
// side, a local copy of the counters, reference bytes and thresholds predicts
// every enroll result, and each strobed result is compared with the oldest one
// ----------------------------------------------------------------------------
module sram_puf_enrollment_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import spe_pkg::*;

    // the one action code the core has no use for
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam int CYCLE_LIMIT = 1_000_000;
    // settle margin after the last expected strobe
    localparam int SETTLE_CYCLES = 4;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    spe_in_t              item = '0;
    spe_out_t             result;
    logic                 result_strobe;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // mirror of the core state, updated at each accepted word
    logic [CNT_W-1:0]     cell_counts [WINDOW_BYTES*LANES];
    logic [7:0]           ref_bytes [WINDOW_BYTES];
    bit                   ref_valid [WINDOW_BYTES];
    logic [TOTAL_W-1:0]   cfg_total;
    logic [TOL_W-1:0]     cfg_tol;

    // enroll results still to come, oldest first
    spe_out_t             pending_keys [$];

    int                   mismatch_count = 0;
    int                   cycle_count = 0;
    // set during one long stretch where the sender draws no random pauses
    bit                   steady_flow = 1'b0;

    sram_puf_enrollment_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .result        (result),
        .result_strobe (result_strobe),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    // hard stop in case the core hangs
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count = mismatch_count + 1;
        $display("MISMATCH at %0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    // a cell is stable when its share of ones sits outside the tolerance band,
    // compared as exact cross products
    function automatic bit cell_is_stable(input logic [CNT_W-1:0] ones);
        longint unsigned scaled;
        longint unsigned hi_bound;
        longint unsigned lo_bound;
        scaled   = longint'(ones) * SCALE;
        hi_bound = longint'(SCALE - int'(cfg_tol)) * longint'(cfg_total);
        lo_bound = longint'(cfg_tol) * longint'(cfg_total);
        return (scaled >= hi_bound) || (scaled <= lo_bound);
    endfunction

    // apply one accepted word to the mirror, queue the enroll result if any
    task automatic predict_enrollment(input spe_in_t w);
        spe_out_t   key_word;
        logic [7:0] mask;
        int         base;
        base = int'(w.byte_index) * LANES;
        case (w.action)
            ACT_ACCUM:
            begin
                // bit 7 feeds lane 0, counters stick at full scale
                for (int lane = 0; lane < LANES; lane++)
                begin
                    if (w.sample_byte[7-lane] && cell_counts[base+lane] != CNT_MAX)
                    begin
                        cell_counts[base+lane] = cell_counts[base+lane] + 1'b1;
                    end
                end
            end
            ACT_STORE:
            begin
                ref_bytes[w.byte_index] = w.sample_byte;
                ref_valid[w.byte_index] = 1'b1;
            end
            ACT_ENROLL:
            begin
                mask = '0;
                for (int lane = 0; lane < LANES; lane++)
                begin
                    mask[7-lane] = cell_is_stable(cell_counts[base+lane]);
                end
                key_word.out_index   = w.byte_index;
                key_word.key_byte    = ref_bytes[w.byte_index] & mask;
                key_word.mask_byte   = mask;
                // repetition code of the key msb
                key_word.helper_byte = key_word.key_byte ^ {8{key_word.key_byte[7]}};
                pending_keys.push_back(key_word);
            end
            default:
            begin
                // unused action code, no effect
            end
        endcase
    endtask

    // strobed results are compared field by field with the oldest expectation
    always @(posedge clk)
    begin : check_results
        spe_out_t want;
        if (rst_n && result_strobe === 1'b1)
        begin
            if (pending_keys.size() == 0)
            begin
                report_mismatch("unexpected result, index", result.out_index, '0);
            end
            else
            begin
                want = pending_keys.pop_front();
                if (result.out_index !== want.out_index)
                    report_mismatch("out_index", result.out_index, want.out_index);
                if (result.key_byte !== want.key_byte)
                    report_mismatch("key_byte", result.key_byte, want.key_byte);
                if (result.mask_byte !== want.mask_byte)
                    report_mismatch("mask_byte", result.mask_byte, want.mask_byte);
                if (result.helper_byte !== want.helper_byte)
                    report_mismatch("helper_byte", result.helper_byte, want.helper_byte);
            end
        end
    end

    // one word on the command side; start stays high unless a pause is drawn
    task automatic send_word(input logic [1:0] action, input int idx, input logic [7:0] data);
        @(negedge clk);
        start           = 1'b1;
        item.action     = action;
        item.byte_index = idx[4:0];
        item.sample_byte = data;
        do @(posedge clk); while (busy !== 1'b0);
        predict_enrollment(item);
        if (!steady_flow && $urandom_range(0, 99) < 9)
        begin
            // drop start until the next word
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    // stop sending and let every result in flight come out
    task automatic drain_pipe();
        @(negedge clk);
        start = 1'b0;
        while (pending_keys.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [PADDR_W-1:0] reg_addr(input logic sel);
        return PADDR_W'({sel, 2'b00});
    endfunction

    // apb access: setup cycle, then access cycle until pready
    task automatic apb_access(input logic sel, input bit is_write, input logic [31:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = is_write;
        paddr   = reg_addr(sel);
        pwdata  = is_write ? data : '0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (is_write)
        begin
            if (sel == REG_SAMPLE_TOTAL)
                cfg_total = data[TOTAL_W-1:0];
            else
                cfg_tol = data[TOL_W-1:0];
        end
        else if (prdata !== data)
        begin
            report_mismatch(sel == REG_SAMPLE_TOTAL ? "read sample_total" : "read tolerance",
                            prdata, data);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // both registers written and read back while nothing is in flight
    task automatic set_thresholds(input int total, input int tol);
        drain_pipe();
        apb_access(REG_SAMPLE_TOTAL, 1'b1, 32'(total));
        apb_access(REG_TOLERANCE, 1'b1, 32'(tol));
        apb_access(REG_SAMPLE_TOTAL, 1'b0, 32'(total));
        apb_access(REG_TOLERANCE, 1'b0, 32'(tol));
    endtask

    function automatic int pick_stored_index();
        int idx;
        do idx = $urandom_range(0, WINDOW_BYTES - 1); while (!ref_valid[idx]);
        return idx;
    endfunction

    // every action at the window edges and on row 5 under the reset thresholds
    task automatic test_basic_actions();
        // reset value of both registers
        apb_access(REG_SAMPLE_TOTAL, 1'b0, 32'(TOTAL_RST));
        apb_access(REG_TOLERANCE, 1'b0, 32'(TOL_RST));
        send_word(ACT_STORE, 0, 8'hFF);
        send_word(ACT_STORE, 31, 8'hA5);
        send_word(ACT_ACCUM, 0, 8'hFF);
        send_word(ACT_ACCUM, 0, 8'h80);
        send_word(ACT_ACCUM, 0, 8'h01);
        send_word(ACT_ACCUM, 31, 8'h00);
        // enroll both rows behind their accumulates, with one other word between
        send_word(ACT_ENROLL, 0, 8'hFF);
        send_word(ACT_ENROLL, 31, 8'h00);
        // unused action must leave the row untouched
        send_word(ACT_NONE, 5, 8'hFF);
        send_word(ACT_STORE, 5, 8'h3C);
        send_word(ACT_ENROLL, 5, 8'h5A);
        send_word(ACT_ACCUM, 0, 8'hFF);
        send_word(ACT_ENROLL, 0, 8'h00);
        send_word(ACT_STORE, 0, 8'h00);
        send_word(ACT_ENROLL, 0, 8'hFF);
        send_word(ACT_NONE, 31, 8'h7F);
        send_word(ACT_ENROLL, 31, 8'h80);
        drain_pipe();
    endtask

    // threshold extremes: zero total, full total, tolerance past its range
    task automatic test_config_extremes();
        int totals [7] = '{0, 0, 65535, 1, 65535, 1, 1000};
        int tols   [7] = '{0, 511, 499, 511, 0, 0, 1};
        for (int k = 0; k < 7; k++)
        begin
            set_thresholds(totals[k], tols[k]);
            send_word(ACT_ENROLL, 0, 8'h00);
            send_word(ACT_ACCUM, 5, 8'(8'h11 << (k % 4)));
            send_word(ACT_ENROLL, 5, 8'h00);
            send_word(ACT_ENROLL, 31, 8'hFF);
        end
        drain_pipe();
    endtask

    // biased accumulation bursts on a few rows, thresholds placed near the
    // resulting counts, then enrolls mixed with stores and noise
    task automatic test_random_enrollment();
        int         rows [4];
        int         bias [4][LANES];
        int         rounds;
        int         row;
        int         lane;
        int         roll;
        logic [CNT_W-1:0] ones;
        logic [7:0] sample;
        for (int phase = 0; phase < 6; phase++)
        begin
            steady_flow = (phase == 3);
            rounds = $urandom_range(10, 40);
            for (int r = 0; r < 4; r++)
            begin
                rows[r] = $urandom_range(0, WINDOW_BYTES - 1);
                for (int b = 0; b < LANES; b++)
                    bias[r][b] = $urandom_range(0, 3);
            end
            // accumulation burst
            for (int n = 0; n < rounds; n++)
            begin
                for (int r = 0; r < 4; r++)
                begin
                    for (int b = 0; b < LANES; b++)
                    begin
                        case (bias[r][b])
                            0: sample[7-b] = 1'b0;
                            1: sample[7-b] = 1'b1;
                            2: sample[7-b] = $urandom_range(0, 1);
                            default: sample[7-b] = ($urandom_range(0, 9) != 0);
                        endcase
                    end
                    send_word(ACT_ACCUM, rows[r], sample);
                    roll = $urandom_range(0, 99);
                    if (roll < 5)
                        send_word(ACT_NONE, $urandom_range(0, 31), 8'($urandom));
                    else if (roll < 10)
                        send_word(ACT_STORE, $urandom_range(0, 31), 8'($urandom));
                end
            end
            for (int r = 0; r < 4; r++)
                send_word(ACT_STORE, rows[r], 8'($urandom));
            // thresholds mostly taken from one lane's count so the compare sits near its edge
            row  = rows[$urandom_range(0, 3)];
            lane = $urandom_range(0, LANES - 1);
            ones = cell_counts[row*LANES + lane];
            case ($urandom_range(0, 3))
                0: set_thresholds(int'(ones), 0);
                1: set_thresholds(1000, (ones <= 511) ? int'(ones) : $urandom_range(0, 511));
                2: set_thresholds(int'(ones) + $urandom_range(0, 6), $urandom_range(0, 150));
                default: set_thresholds($urandom_range(1, 65535), $urandom_range(0, 511));
            endcase
            // enroll section
            for (int n = 0; n < 70; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    send_word(ACT_ENROLL, rows[$urandom_range(0, 3)], 8'($urandom));
                else if (roll < 70)
                    send_word(ACT_ENROLL, pick_stored_index(), 8'($urandom));
                else if (roll < 85)
                    send_word(ACT_STORE, $urandom_range(0, 31), 8'($urandom));
                else if (roll < 95)
                    send_word(ACT_ACCUM, rows[$urandom_range(0, 3)], 8'($urandom));
                else
                    send_word(ACT_NONE, $urandom_range(0, 31), 8'($urandom));
            end
        end
        steady_flow = 1'b0;
        drain_pipe();
    endtask

    // drive the upper lanes of one row far above the lower ones, then enroll
    // under loose and tight settings
    task automatic test_counter_spread();
        localparam int SPREAD_ROW = 7;
        send_word(ACT_STORE, SPREAD_ROW, 8'hC3);
        for (int n = 0; n < 40; n++)
            send_word(ACT_ACCUM, SPREAD_ROW, 8'hF0);
        send_word(ACT_ACCUM, SPREAD_ROW, 8'h0F);
        send_word(ACT_ENROLL, SPREAD_ROW, 8'h00);
        set_thresholds(2, 0);
        send_word(ACT_ENROLL, SPREAD_ROW, 8'h00);
        send_word(ACT_ACCUM, SPREAD_ROW, 8'hFF);
        send_word(ACT_ENROLL, SPREAD_ROW, 8'hFF);
        set_thresholds(65535, 0);
        send_word(ACT_ENROLL, SPREAD_ROW, 8'h00);
        drain_pipe();
    endtask

    initial
    begin
        for (int i = 0; i < WINDOW_BYTES*LANES; i++)
            cell_counts[i] = '0;
        for (int i = 0; i < WINDOW_BYTES; i++)
        begin
            ref_bytes[i] = '0;
            ref_valid[i] = 1'b0;
        end
        cfg_total = TOTAL_RST;
        cfg_tol   = TOL_RST;

        // single reset at the start of the run
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_basic_actions();
        test_config_extremes();
        test_random_enrollment();
        test_counter_spread();

        // let anything still in flight come out before the verdict
        drain_pipe();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/spe_pkg.sv
rtl/spe_ram.sv
rtl/spe_lane.sv
rtl/spe_merge.sv
rtl/sram_puf_enrollment_core.sv
tb/sram_puf_enrollment_core_tb.sv
